@@ rtl/core/ntc_pkg.sv @@
// Package: constants, types and pipeline taps of the NTC thermistor converter.
`default_nettype none
package ntc_pkg;

  localparam int ADC_BITS = 12;
  localparam int CODE_W = 12;
  localparam logic [ADC_BITS-1:0] CODE_FULL = {ADC_BITS{1'b1}};

  localparam int RES_W = 20;
  localparam int BETA_W = 16;
  localparam int PROD_W = RES_W + ADC_BITS;
  localparam int P_W = $clog2(PROD_W);
  localparam int M_W = 32;
  localparam int LOG_FRAC = 28;
  localparam int LOG_W = P_W + LOG_FRAC;

  localparam logic [27:0] LN2_Q28 = 28'd186065279;
  localparam int T0_CENTI = 29815;
  localparam int ZERO_C_CENTI = 27315;
  localparam int TK_MAX = 32767 + ZERO_C_CENTI;

  localparam int L24_W = LOG_W - 2;
  localparam int T_W = L24_W + 15;
  localparam int DEN_W = 49;
  localparam int DENU_W = DEN_W - 1;
  localparam int BK100_W = 23;
  localparam int BNUM_W = 38;
  localparam int N_W = 64;
  localparam int Q_W = 16;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_ZERO = 3'd2;
  localparam logic [2:0] ST_DENBAD = 3'd3;
  localparam logic [2:0] ST_SAT = 3'd4;

  // pipeline taps (register index of each stage)
  localparam int LOG_LAT = 1 + LOG_FRAC;
  localparam int S_IN = 1;
  localparam int S_LOG = S_IN + LOG_LAT;
  localparam int S_SIGN = S_LOG + 1;
  localparam int S_L24 = S_SIGN + 1;
  localparam int S_T = S_L24 + 1;
  localparam int S_DEN = S_T + 1;
  localparam int S_N = S_DEN + 1;
  localparam int DIV_STAGES = Q_W;
  localparam int S_Q = S_N + DIV_STAGES;

  typedef enum logic [2:0] {
    K_OK,
    K_FULL,
    K_ZERO,
    K_NOMZ,
    K_DENBAD,
    K_SAT
  } kind_t;

endpackage
`default_nettype wire

@@ rtl/core/ntc_log2_pipe.sv @@
// Pipelined log2 in Q.28: normalize stage, then one squaring stage per fraction bit.
`default_nettype none
module ntc_log2_pipe (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [ntc_pkg::PROD_W-1:0] x,
  output logic      [ntc_pkg::LOG_W-1:0]  lg
);

  localparam int NS = ntc_pkg::LOG_FRAC;
  localparam int MW = ntc_pkg::M_W;

  logic [ntc_pkg::P_W-1:0] pos;
  logic [63:0] xw;
  logic [MW-1:0] mnorm;

  logic [MW-1:0] m [0:NS];
  logic [ntc_pkg::P_W-1:0] p [0:NS];
  logic [NS-1:0] f [0:NS];
  logic [MW:0] sh [1:NS];

  // leading one
  always_comb begin
    pos = '0;
    for (int i = 0; i < ntc_pkg::PROD_W; i++) begin
      if (x[i]) pos = ntc_pkg::P_W'(i);
    end
    xw = 64'(x);
    if (int'(pos) <= MW - 1) begin
      mnorm = MW'(xw << (MW - 1 - int'(pos)));
    end else begin
      mnorm = MW'(xw >> (int'(pos) - (MW - 1)));
    end
  end

  always_comb begin
    for (int s = 1; s <= NS; s++) begin
      sh[s] = (MW+1)'((64'(m[s-1]) * 64'(m[s-1])) >> (MW - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m[0] <= mnorm;
      p[0] <= pos;
      f[0] <= '0;
      for (int s = 1; s <= NS; s++) begin
        m[s] <= sh[s][MW] ? sh[s][MW:1] : sh[s][MW-1:0];
        f[s] <= {f[s-1][NS-2:0], sh[s][MW]};
        p[s] <= p[s-1];
      end
    end
  end

  assign lg = {p[NS], f[NS]};

endmodule
`default_nettype wire

@@ rtl/core/ntc_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per stage, quotient known to fit.
`default_nettype none
module ntc_div_pipe (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [ntc_pkg::N_W-1:0]    num,
  input  wire logic [ntc_pkg::DENU_W-1:0] den,
  output logic      [ntc_pkg::Q_W-1:0]    quo
);

  localparam int NS = ntc_pkg::DIV_STAGES;
  localparam int NW = ntc_pkg::N_W;

  logic [NW-1:0] r [0:NS-1];
  logic [ntc_pkg::DENU_W-1:0] d [0:NS-1];
  logic [NS-1:0] q [0:NS-1];
  logic [NW-1:0] sub0;
  logic [NW-1:0] subs [1:NS-1];

  assign sub0 = NW'(den) << (NS - 1);

  always_comb begin
    for (int s = 1; s < NS; s++) begin
      subs[s] = NW'(d[s-1]) << (NS - 1 - s);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d[0] <= den;
      if (num >= sub0) begin
        r[0] <= num - sub0;
        q[0] <= NS'(1);
      end else begin
        r[0] <= num;
        q[0] <= '0;
      end
      for (int s = 1; s < NS; s++) begin
        d[s] <= d[s-1];
        if (r[s-1] >= subs[s]) begin
          r[s] <= r[s-1] - subs[s];
          q[s] <= {q[s-1][NS-2:0], 1'b1};
        end else begin
          r[s] <= r[s-1];
          q[s] <= {q[s-1][NS-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q[NS-1];

endmodule
`default_nettype wire

@@ rtl/core/ntc_adc_to_celsius.sv @@
// Top level: NTC thermistor ADC code to temperature in hundredths of a degree C.
//
// Input channel (in_valid/in_ready/adc_code) takes one ADC code per transfer;
// output channel (out_valid/out_ready/temp_centi_c/status) gives one result per
// input, in order. Status: 0 ok, 1 full-scale code, 2 zero resistance,
// 3 reciprocal not positive, 4 saturated; temp is 0 for status 1..3.
// The whole path is one pipeline of 52 register stages: two 20x12 products,
// two log2 units of 29 stages (normalize plus one squaring per fraction bit),
// the ln2 scale and Beta denominator over four stages, an overflow check and
// a 16-stage restoring divider, then the output register.
// Throughput: one transfer per cycle, sustained while out_ready stays high.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated, and bubbles also hold.
// Reset (rst, synchronous) drops all valid bits and loads the registers with
// divider 10000 ohms, nominal 10000 ohms, Beta 3950 K.
// Configuration writes (cfg_write/cfg_index/cfg_data) take effect at once and
// belong to idle periods; indexes beyond Beta are ignored.
`default_nettype none
module ntc_adc_to_celsius (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [ntc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ntc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ntc_pkg::CODE_W-1:0]     adc_code,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [15:0]                  temp_centi_c,
  output logic [2:0]                          status
);

  localparam int LAST = ntc_pkg::S_Q;

  // configuration
  logic [ntc_pkg::RES_W-1:0] divider_ohms;
  logic [ntc_pkg::RES_W-1:0] nominal_ohms;
  logic [ntc_pkg::BETA_W-1:0] beta_kelvin;
  logic [ntc_pkg::BK100_W-1:0] bk100;   // 100*B, rebuilt every cycle
  logic [ntc_pkg::BNUM_W-1:0] bnum;     // 2981500*B

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_ohms <= ntc_pkg::RES_W'(10000);
      nominal_ohms <= ntc_pkg::RES_W'(10000);
      beta_kelvin <= ntc_pkg::BETA_W'(3950);
    end else if (cfg_write) begin
      case (cfg_index)
        ntc_pkg::REG_DIVIDER: divider_ohms <= cfg_data;
        ntc_pkg::REG_NOMINAL: nominal_ohms <= cfg_data;
        ntc_pkg::REG_BETA: beta_kelvin <= cfg_data[ntc_pkg::BETA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    bk100 <= ntc_pkg::BK100_W'(beta_kelvin) * ntc_pkg::BK100_W'(100);
    bnum <= ntc_pkg::BNUM_W'(beta_kelvin) * ntc_pkg::BNUM_W'(2981500);
  end

  // global advance: pipe moves when the output register is free or drains
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // valid and kind travel alongside the data
  logic v [1:LAST];
  ntc_pkg::kind_t k [1:LAST];

  // stage 1: classify, divider products
  logic [ntc_pkg::ADC_BITS-1:0] code;
  ntc_pkg::kind_t kind_in;
  logic [ntc_pkg::PROD_W-1:0] a1, b1;

  assign code = adc_code[ntc_pkg::ADC_BITS-1:0];

  always_comb begin
    if (code == ntc_pkg::CODE_FULL) kind_in = ntc_pkg::K_FULL;
    else if (code == '0 || divider_ohms == '0) kind_in = ntc_pkg::K_ZERO;
    else if (nominal_ohms == '0) kind_in = ntc_pkg::K_NOMZ;
    else kind_in = ntc_pkg::K_OK;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= ntc_pkg::PROD_W'(divider_ohms) * ntc_pkg::PROD_W'(code);
      b1 <= ntc_pkg::PROD_W'(nominal_ohms) * ntc_pkg::PROD_W'(ntc_pkg::CODE_FULL - code);
    end
  end

  // log2 of both sides
  logic [ntc_pkg::LOG_W-1:0] la, lb;

  ntc_log2_pipe u_log_a (.clk(clk), .en(en), .x(a1), .lg(la));
  ntc_log2_pipe u_log_b (.clk(clk), .en(en), .x(b1), .lg(lb));

  // sign/magnitude of the log difference
  logic signed [ntc_pkg::LOG_W:0] dl;
  logic neg_s;
  logic [ntc_pkg::LOG_W-1:0] mag_s;
  assign dl = $signed({1'b0, la}) - $signed({1'b0, lb});

  // l24 = round(|d| * ln2), Q.24, sign restored
  logic [ntc_pkg::LOG_W+27:0] lnp;
  logic [ntc_pkg::LOG_W+27:0] l24m;
  logic signed [ntc_pkg::L24_W-1:0] l24;
  logic signed [ntc_pkg::T_W-1:0] tprod;
  logic signed [ntc_pkg::DEN_W-1:0] den_next, den_s;
  logic den_bad;
  logic [ntc_pkg::N_W-1:0] n_next, n_s;
  logic [ntc_pkg::DENU_W-1:0] dv_s;
  logic ovf;

  assign lnp = (ntc_pkg::LOG_W+28)'(mag_s) * (ntc_pkg::LOG_W+28)'(ntc_pkg::LN2_Q28);
  assign l24m = (lnp + (ntc_pkg::LOG_W+28)'(64'd1 << 31)) >> 32;

  assign den_next = $signed({2'b00, bk100, 24'b0}) + ntc_pkg::DEN_W'(tprod);
  assign den_bad = den_next[ntc_pkg::DEN_W-1] || den_next == '0;

  assign n_next = ntc_pkg::N_W'({bnum, 24'b0})
                + ntc_pkg::N_W'(den_s[ntc_pkg::DENU_W-1:1]);
  assign ovf = n_next >= (ntc_pkg::N_W'(den_s[ntc_pkg::DENU_W-1:0]) << ntc_pkg::Q_W);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_s <= dl[ntc_pkg::LOG_W];
      mag_s <= dl[ntc_pkg::LOG_W] ? ntc_pkg::LOG_W'(-dl) : ntc_pkg::LOG_W'(dl);
      l24 <= neg_s ? -$signed(ntc_pkg::L24_W'(l24m)) : $signed(ntc_pkg::L24_W'(l24m));
      tprod <= ntc_pkg::T_W'(l24) * $signed(ntc_pkg::T_W'(ntc_pkg::T0_CENTI));
      den_s <= den_next;
      n_s <= n_next;
      dv_s <= den_s[ntc_pkg::DENU_W-1:0];
    end
  end

  // final division
  logic [ntc_pkg::Q_W-1:0] tk;
  ntc_div_pipe u_div (.clk(clk), .en(en), .num(n_s), .den(dv_s), .quo(tk));

  // side line
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= LAST; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[1] <= in_valid;
      for (int i = 2; i <= LAST; i++) v[i] <= v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k[1] <= kind_in;
      for (int i = 2; i <= LAST; i++) begin
        if (i == ntc_pkg::S_DEN && k[i-1] == ntc_pkg::K_OK && den_bad) begin
          k[i] <= ntc_pkg::K_DENBAD;
        end else if (i == ntc_pkg::S_N && k[i-1] == ntc_pkg::K_OK && ovf) begin
          k[i] <= ntc_pkg::K_SAT;
        end else begin
          k[i] <= k[i-1];
        end
      end
    end
  end

  // result formatting
  logic signed [15:0] temp_next;
  logic [2:0] status_next;

  always_comb begin
    temp_next = '0;
    status_next = ntc_pkg::ST_OK;
    case (k[LAST])
      ntc_pkg::K_OK: begin
        if (int'(tk) > ntc_pkg::TK_MAX) begin
          temp_next = 16'sd32767;
          status_next = ntc_pkg::ST_SAT;
        end else begin
          temp_next = 16'(17'(tk) - 17'(ntc_pkg::ZERO_C_CENTI));
        end
      end
      ntc_pkg::K_SAT: begin
        temp_next = 16'sd32767;
        status_next = ntc_pkg::ST_SAT;
      end
      ntc_pkg::K_FULL: status_next = ntc_pkg::ST_FULL;
      ntc_pkg::K_ZERO: status_next = ntc_pkg::ST_ZERO;
      ntc_pkg::K_DENBAD: status_next = ntc_pkg::ST_DENBAD;
      ntc_pkg::K_NOMZ: temp_next = 16'(-ntc_pkg::ZERO_C_CENTI);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_centi_c <= temp_next;
      status <= status_next;
    end
  end

`ifndef SYNTH
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ntc_pkg::ST_FULL || status == ntc_pkg::ST_ZERO ||
                  status == ntc_pkg::ST_DENBAD) |-> temp_centi_c == 16'sd0)
    else $error("error status with nonzero temperature");
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ntc_pkg::ST_SAT |-> temp_centi_c == 16'sd32767)
    else $error("saturated result not at upper clamp");
  a_ok_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ntc_pkg::ST_OK |-> temp_centi_c >= -16'sd27315)
    else $error("temperature below absolute zero");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v[LAST]) && $stable(k[LAST]))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
